>>> sv/irpd_pkg.sv
// Shared types and constants for the IR pulse-distance bit decoder.
`timescale 1ns / 1ps

package irpd_pkg;

  // Field widths and limits
  localparam int LEN_WIDTH  = 16;
  localparam int CNT_WIDTH  = 6;
  localparam int CODE_WIDTH = 32;
  localparam int MAX_BITS   = 48;

  // Stream and register port widths
  localparam int IN_DATA_WIDTH  = 16;
  localparam int IN_USER_WIDTH  = 2;
  localparam int OUT_DATA_WIDTH = 40;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 4;
  localparam int REG_IDX_WIDTH  = 2;

  // Register indexes (byte address is 4 times the index)
  localparam logic [REG_IDX_WIDTH-1:0] REG_GAP_LIMIT    = 2'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_HEADER_LIMIT = 2'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ONE_LIMIT    = 2'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_MIN_BITS     = 2'd3;

  // Register reset values
  localparam logic [LEN_WIDTH-1:0] GAP_LIMIT_RST    = 16'd10000;
  localparam logic [LEN_WIDTH-1:0] HEADER_LIMIT_RST = 16'd2000;
  localparam logic [LEN_WIDTH-1:0] ONE_LIMIT_RST    = 16'd1000;
  localparam logic [CNT_WIDTH-1:0] MIN_BITS_RST     = 6'd3;

  typedef struct packed {
    logic [LEN_WIDTH-1:0] gap_limit;
    logic [LEN_WIDTH-1:0] header_limit;
    logic [LEN_WIDTH-1:0] one_limit;
    logic [CNT_WIDTH-1:0] min_bits;
  } cfg_t;

  typedef struct packed {
    logic                 timer_overflow;
    logic                 is_low;
    logic [LEN_WIDTH-1:0] pulse_len;
  } pulse_t;

  typedef struct packed {
    logic                  emit;
    logic [CNT_WIDTH-1:0]  bit_count;
    logic [CODE_WIDTH-1:0] code;
  } result_t;

endpackage

>>> sv/ir_pulse_distance_bit_decoder_unit.sv
// Top level of the IR pulse-distance bit decoder.
`timescale 1ns / 1ps
//
// Usage: each item on the s_ channel is one measured IR pulse (length in
// microseconds on s_tdata, level and timer-overflow flags on s_tuser).
// Gaps, headers and data bits are decoded; a finished code leaves on the
// m_ channel as one item holding the 32-bit code and the bit count.
// Thresholds live in four APB registers: gap_limit at 0x0, header_limit at
// 0x4, one_limit at 0x8, min_bits at 0xC; write them only while idle.
// A result reaches m_tvalid through the input register, then the result
// register. Throughput: one pulse per cycle while no result waits on the
// receiver; the decision is a handful of 16-bit compares and a 32-bit shift
// between the two registers.
// Reset clears the packet state, both stages and restores register defaults.
// When the receiver stalls, the pending result holds in the result register,
// one more pulse is taken into the input register, then s_tready drops
// until the result is taken.
//
module ir_pulse_distance_bit_decoder_unit (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: [15:0] pulse_len
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [irpd_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
  // s_tuser: [0] is_low, [1] timer_overflow
  input  logic [irpd_pkg::IN_USER_WIDTH-1:0]  s_tuser,
  // m_tdata: [31:0] code, [37:32] bit_count, [39:38] zero
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [irpd_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [irpd_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [irpd_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [irpd_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);

  irpd_pkg::cfg_t    cfg;
  irpd_pkg::pulse_t  in_item;
  irpd_pkg::result_t result;
  logic              in_valid;
  logic              advance;
  logic [irpd_pkg::CODE_WIDTH-1:0] out_code;
  logic [irpd_pkg::CNT_WIDTH-1:0]  out_count;

  irpd_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irpd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (in_item),
    .advance (advance),
    .result  (result)
  );

  // Advance the input stage when the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.pulse_len      <= s_tdata[irpd_pkg::LEN_WIDTH-1:0];
      in_item.is_low         <= s_tuser[0];
      in_item.timer_overflow <= s_tuser[1];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= result.emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_code  <= result.code;
      out_count <= result.bit_count;
    end
  end

  assign m_tdata = {2'b00, out_count, out_code};

  // A stalled input means both stages are full and the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  // An emitted code always carries at least one bit
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37:32] != '0))
    else $error("result emitted with zero bit count");

  // The bit count never passes the full-code length
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37:32] <= irpd_pkg::CNT_WIDTH'(irpd_pkg::MAX_BITS)))
    else $error("result bit count above full-code length");

  // Nothing is shown right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

>>> sv/irpd_cfg_regs.sv
// APB register file holding the decoder thresholds.
`timescale 1ns / 1ps

module irpd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [irpd_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [irpd_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [irpd_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready,
  output irpd_pkg::cfg_t                      cfg
);

  logic                                wr_en;
  logic [irpd_pkg::REG_IDX_WIDTH-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[irpd_pkg::APB_ADDR_WIDTH-1:2];

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_limit    <= irpd_pkg::GAP_LIMIT_RST;
      cfg.header_limit <= irpd_pkg::HEADER_LIMIT_RST;
      cfg.one_limit    <= irpd_pkg::ONE_LIMIT_RST;
      cfg.min_bits     <= irpd_pkg::MIN_BITS_RST;
    end else if (wr_en) begin
      case (idx)
        irpd_pkg::REG_GAP_LIMIT:    cfg.gap_limit    <= pwdata[irpd_pkg::LEN_WIDTH-1:0];
        irpd_pkg::REG_HEADER_LIMIT: cfg.header_limit <= pwdata[irpd_pkg::LEN_WIDTH-1:0];
        irpd_pkg::REG_ONE_LIMIT:    cfg.one_limit    <= pwdata[irpd_pkg::LEN_WIDTH-1:0];
        irpd_pkg::REG_MIN_BITS:     cfg.min_bits     <= pwdata[irpd_pkg::CNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero-extended
  always_comb begin
    case (idx)
      irpd_pkg::REG_GAP_LIMIT:
        prdata = irpd_pkg::APB_DATA_WIDTH'(cfg.gap_limit);
      irpd_pkg::REG_HEADER_LIMIT:
        prdata = irpd_pkg::APB_DATA_WIDTH'(cfg.header_limit);
      irpd_pkg::REG_ONE_LIMIT:
        prdata = irpd_pkg::APB_DATA_WIDTH'(cfg.one_limit);
      irpd_pkg::REG_MIN_BITS:
        prdata = irpd_pkg::APB_DATA_WIDTH'(cfg.min_bits);
      default:
        prdata = '0;
    endcase
  end

endmodule

>>> sv/irpd_decode.sv
// Packet state and single-pass decision logic for one pulse.
`timescale 1ns / 1ps

module irpd_decode (
  input  logic             clk,
  input  logic             rst,
  input  irpd_pkg::cfg_t   cfg,
  input  irpd_pkg::pulse_t item,
  input  logic             advance,
  output irpd_pkg::result_t result
);

  logic [irpd_pkg::CNT_WIDTH-1:0]  bit_counter;
  logic [irpd_pkg::CODE_WIDTH-1:0] shift_accumulator;
  logic [irpd_pkg::LEN_WIDTH-1:0]  last_low_length;

  logic [irpd_pkg::CNT_WIDTH-1:0]  bit_counter_next;
  logic [irpd_pkg::CODE_WIDTH-1:0] shift_accumulator_next;
  logic [irpd_pkg::LEN_WIDTH-1:0]  last_low_length_next;

  logic                            is_gap;
  logic                            is_header;
  logic                            is_full;
  logic                            bit_val;
  logic [irpd_pkg::CNT_WIDTH-1:0]  cnt_inc;
  logic [irpd_pkg::CODE_WIDTH-1:0] acc_shift;

  assign is_gap    = item.timer_overflow || (item.pulse_len > cfg.gap_limit);
  assign is_header = !item.is_low && ((item.pulse_len > cfg.header_limit) ||
                                      (last_low_length > cfg.header_limit));
  assign is_full   = bit_counter >= irpd_pkg::CNT_WIDTH'(irpd_pkg::MAX_BITS);
  assign bit_val   = (item.pulse_len > cfg.one_limit) ||
                     (last_low_length > cfg.one_limit);
  assign cnt_inc   = bit_counter + irpd_pkg::CNT_WIDTH'(1);
  assign acc_shift = {shift_accumulator[irpd_pkg::CODE_WIDTH-2:0], bit_val};

  // Classify the pulse and form next state and result
  always_comb begin
    bit_counter_next       = bit_counter;
    shift_accumulator_next = shift_accumulator;
    last_low_length_next   = last_low_length;
    result.emit            = 1'b0;
    result.code            = shift_accumulator;
    result.bit_count       = bit_counter;
    if (is_gap) begin
      // Gap: flush the code if enough bits, then clear
      result.emit            = bit_counter > cfg.min_bits;
      bit_counter_next       = '0;
      shift_accumulator_next = '0;
      last_low_length_next   = '0;
    end else if (is_header) begin
      bit_counter_next       = '0;
      shift_accumulator_next = '0;
      last_low_length_next   = '0;
    end else if (item.is_low || is_full) begin
      // Low pulse, or high pulse past a full code: only record length
      last_low_length_next = item.pulse_len;
    end else begin
      // Data bit: shift in and emit once the code is full
      shift_accumulator_next = acc_shift;
      last_low_length_next   = '0;
      bit_counter_next       = cnt_inc;
      result.emit            = cnt_inc >= irpd_pkg::CNT_WIDTH'(irpd_pkg::MAX_BITS);
      result.code            = acc_shift;
      result.bit_count       = cnt_inc;
    end
  end

  // Hold packet state, advance when the item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_counter       <= '0;
      shift_accumulator <= '0;
      last_low_length   <= '0;
    end else if (advance) begin
      bit_counter       <= bit_counter_next;
      shift_accumulator <= shift_accumulator_next;
      last_low_length   <= last_low_length_next;
    end
  end

endmodule

>>> verif/tb_ir_pulse_distance_bit_decoder_unit.sv
// Self-checking testbench for the IR pulse-distance bit decoder unit.
`timescale 1ns / 1ps

module tb_ir_pulse_distance_bit_decoder_unit;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [irpd_pkg::CODE_WIDTH-1:0] code;
    logic [irpd_pkg::CNT_WIDTH-1:0]  bit_count;
  } ir_code_t;

  typedef struct {
    logic [irpd_pkg::LEN_WIDTH-1:0]  len;
    bit                              low;
    bit                              ovf;
    bit                              typed;
    bit                              has_code;
    logic [irpd_pkg::CODE_WIDTH-1:0] code;
    logic [irpd_pkg::CNT_WIDTH-1:0]  bit_count;
  } pulse_row_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [irpd_pkg::IN_DATA_WIDTH-1:0]  s_tdata = '0;   // [15:0] pulse_len
  logic [irpd_pkg::IN_USER_WIDTH-1:0]  s_tuser = '0;   // [0] is_low, [1] timer_overflow
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [irpd_pkg::OUT_DATA_WIDTH-1:0] m_tdata;        // [31:0] code, [37:32] bit_count
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [irpd_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [irpd_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [irpd_pkg::APB_DATA_WIDTH-1:0] prdata;
  logic                                pready;

  // Predictor state and register copy
  irpd_pkg::cfg_t                      thresholds;
  logic [irpd_pkg::CNT_WIDTH-1:0]      bits_seen;
  logic [irpd_pkg::CODE_WIDTH-1:0]     code_shift;
  logic [irpd_pkg::LEN_WIDTH-1:0]      prev_low_len;

  ir_code_t codes_due[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       sent = 0;
  bit       idle_mode = 1'b1;
  bit       hold_off_req = 1'b0;

  // Directed pulses under the reset thresholds
  pulse_row_t directed_rows [24] = '{
    '{16'd65535, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 6'd0},  // overlong pulse, nothing held
    '{16'd0,     1'b1, 1'b1, 1'b1, 1'b0, 32'd0, 6'd0},  // overflow on empty state
    '{16'd9000,  1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd4500,  1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 6'd0},  // header
    '{16'd560,   1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd560,   1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd560,   1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd1690,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd1690,  1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd560,   1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},  // zero-length high after a bit
    '{16'd0,     1'b1, 1'b1, 1'b1, 1'b1, 32'd6, 6'd4},  // overflow emits 0110
    '{16'd1001,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd1000,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd2001,  1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd2000,  1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 6'd0},  // header from the low pulse
    '{16'd10000, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0, 6'd0},  // at gap limit: header
    '{16'd500,   1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd1500,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd700,   1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd2500,  1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd10001, 1'b1, 1'b0, 1'b1, 1'b0, 32'd0, 6'd0},  // gap with only min_bits bits
    '{16'd1200,  1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 6'd0},
    '{16'd65535, 1'b0, 1'b1, 1'b1, 1'b0, 32'd0, 6'd0}   // overflow on a single bit
  };

  ir_pulse_distance_bit_decoder_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Decode one pulse; return 1 when it yields a code
  function automatic bit predict_pulse(input irpd_pkg::pulse_t p, output ir_code_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    if (p.timer_overflow || p.pulse_len > thresholds.gap_limit) begin
      hit = bits_seen > thresholds.min_bits;
      res = '{code_shift, bits_seen};
      bits_seen = '0;
      code_shift = '0;
      prev_low_len = '0;
    end else if (!p.is_low && (p.pulse_len > thresholds.header_limit ||
                               prev_low_len > thresholds.header_limit)) begin
      bits_seen = '0;
      code_shift = '0;
      prev_low_len = '0;
    end else if (p.is_low || bits_seen >= irpd_pkg::CNT_WIDTH'(irpd_pkg::MAX_BITS)) begin
      // record low length; after a full code a high pulse only takes its place
      prev_low_len = p.pulse_len;
    end else begin
      code_shift = {code_shift[irpd_pkg::CODE_WIDTH-2:0],
                    p.pulse_len > thresholds.one_limit || prev_low_len > thresholds.one_limit};
      prev_low_len = '0;
      bits_seen = bits_seen + irpd_pkg::CNT_WIDTH'(1);
      if (bits_seen >= irpd_pkg::CNT_WIDTH'(irpd_pkg::MAX_BITS)) begin
        hit = 1'b1;
        res = '{code_shift, bits_seen};
      end
    end
    return hit;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(99, 0);
    if (r < 75) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(8, 4);
    return $urandom_range(60, 20);
  endfunction

  // Hand one pulse over, optionally after an idle stretch
  task automatic drive_pulse(input irpd_pkg::pulse_t p);
    if (idle_mode && $urandom_range(9, 0) < 3) begin
      s_tvalid <= 1'b0;
      repeat (gap_cycles()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p.pulse_len;
    s_tuser <= {p.timer_overflow, p.is_low};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_pulse(input logic [irpd_pkg::LEN_WIDTH-1:0] len, input bit low,
                            input bit ovf);
    irpd_pkg::pulse_t p;
    ir_code_t         res;
    p = '{ovf, low, len};
    drive_pulse(p);
    if (predict_pulse(p, res)) codes_due.push_back(res);
  endtask

  function automatic int len_between(input int lo, input int hi);
    if (lo > hi) return $urandom_range(65535, 0);
    return $urandom_range(hi, lo);
  endfunction

  function automatic int bit_len();
    int one_i, hdr_i, gap_i, top;
    one_i = int'(thresholds.one_limit);
    hdr_i = int'(thresholds.header_limit);
    gap_i = int'(thresholds.gap_limit);
    top = (hdr_i < gap_i) ? hdr_i : gap_i;
    if ($urandom_range(1, 0)) return len_between(one_i + 1, top);
    return len_between(0, (one_i < top) ? one_i : top);
  endfunction

  // One packet: header, bits, terminator; sometimes noise or a broken one
  task automatic send_burst();
    int nbits, t;
    int hdr_i, gap_i;
    hdr_i = int'(thresholds.header_limit);
    gap_i = int'(thresholds.gap_limit);
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(8, 1))
        send_pulse(($urandom_range(3, 0) == 0) ?
                   {irpd_pkg::LEN_WIDTH{$urandom_range(1, 0) == 1}} :
                   irpd_pkg::LEN_WIDTH'($urandom_range(65535, 0)),
                   $urandom_range(1, 0) == 1, $urandom_range(7, 0) == 0);
    end else begin
      if ($urandom_range(3, 0) != 0) begin
        send_pulse(irpd_pkg::LEN_WIDTH'(len_between(hdr_i + 1, gap_i)), 1'b1, 1'b0);
        send_pulse(irpd_pkg::LEN_WIDTH'(bit_len()), 1'b0, 1'b0);
      end else begin
        send_pulse(irpd_pkg::LEN_WIDTH'(len_between(hdr_i + 1, gap_i)), 1'b0, 1'b0);
      end
      nbits = ($urandom_range(9, 0) < 4) ? $urandom_range(55, 46) : $urandom_range(20, 0);
      repeat (nbits) begin
        if ($urandom_range(9, 0) != 0)
          send_pulse(irpd_pkg::LEN_WIDTH'(bit_len()), 1'b1, 1'b0);
        send_pulse(irpd_pkg::LEN_WIDTH'(bit_len()), 1'b0, 1'b0);
      end
      t = $urandom_range(9, 0);
      if (t < 5)
        send_pulse(irpd_pkg::LEN_WIDTH'($urandom_range(65535, 0)),
                   $urandom_range(1, 0) == 1, 1'b1);
      else if (t < 8)
        send_pulse(irpd_pkg::LEN_WIDTH'(len_between(gap_i + 1, 65535)),
                   $urandom_range(1, 0) == 1, 1'b0);
    end
  endtask

  task automatic write_reg(input logic [irpd_pkg::REG_IDX_WIDTH-1:0] idx,
                           input logic [irpd_pkg::APB_DATA_WIDTH-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      irpd_pkg::REG_GAP_LIMIT:    thresholds.gap_limit = value[irpd_pkg::LEN_WIDTH-1:0];
      irpd_pkg::REG_HEADER_LIMIT: thresholds.header_limit = value[irpd_pkg::LEN_WIDTH-1:0];
      irpd_pkg::REG_ONE_LIMIT:    thresholds.one_limit = value[irpd_pkg::LEN_WIDTH-1:0];
      irpd_pkg::REG_MIN_BITS:     thresholds.min_bits = value[irpd_pkg::CNT_WIDTH-1:0];
      default: ;
    endcase
    // Hold the bus idle between accesses
    @(posedge clk);
  endtask

  // Read back every register against the local copy
  task automatic check_regs();
    logic [irpd_pkg::APB_DATA_WIDTH-1:0] want;
    for (int i = int'(irpd_pkg::REG_GAP_LIMIT); i <= int'(irpd_pkg::REG_MIN_BITS); i++) begin
      case (irpd_pkg::REG_IDX_WIDTH'(i))
        irpd_pkg::REG_GAP_LIMIT:
          want = irpd_pkg::APB_DATA_WIDTH'(thresholds.gap_limit);
        irpd_pkg::REG_HEADER_LIMIT:
          want = irpd_pkg::APB_DATA_WIDTH'(thresholds.header_limit);
        irpd_pkg::REG_ONE_LIMIT:
          want = irpd_pkg::APB_DATA_WIDTH'(thresholds.one_limit);
        default:
          want = irpd_pkg::APB_DATA_WIDTH'(thresholds.min_bits);
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {irpd_pkg::REG_IDX_WIDTH'(i), 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== want)
        report_mismatch($sformatf("register %0d readback", i), 64'(prdata), 64'(want));
      psel <= 1'b0;
      penable <= 1'b0;
      // Hold the bus idle between accesses
      @(posedge clk);
    end
  endtask

  // Drop valid, wait for every code and for the pipeline to empty
  task automatic drain();
    s_tvalid <= 1'b0;
    while (codes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int gap_v, input int hdr_v, input int one_v, input int min_v,
                           input bit idle, input int n_items, input bit pressure);
    drain();
    write_reg(irpd_pkg::REG_GAP_LIMIT, irpd_pkg::APB_DATA_WIDTH'(gap_v));
    write_reg(irpd_pkg::REG_HEADER_LIMIT, irpd_pkg::APB_DATA_WIDTH'(hdr_v));
    write_reg(irpd_pkg::REG_ONE_LIMIT, irpd_pkg::APB_DATA_WIDTH'(one_v));
    write_reg(irpd_pkg::REG_MIN_BITS, irpd_pkg::APB_DATA_WIDTH'(min_v));
    check_regs();
    idle_mode = idle;
    hold_off_req = pressure;
    sent = 0;
    while (sent < n_items) send_burst();
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_mode && $urandom_range(3, 0) == 0) begin
        m_tready <= 1'b0;
        repeat (gap_cycles()) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each code item with the oldest expectation
  always @(posedge clk) begin
    ir_code_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (codes_due.size() == 0) begin
        report_mismatch("unexpected code item", 64'(m_tdata), '0);
      end else begin
        want = codes_due.pop_front();
        if (m_tdata[irpd_pkg::CODE_WIDTH-1:0] !== want.code)
          report_mismatch("code", 64'(m_tdata[irpd_pkg::CODE_WIDTH-1:0]), 64'(want.code));
        if (m_tdata[irpd_pkg::CODE_WIDTH +: irpd_pkg::CNT_WIDTH] !== want.bit_count)
          report_mismatch("bit_count", 64'(m_tdata[irpd_pkg::CODE_WIDTH +: irpd_pkg::CNT_WIDTH]),
                          64'(want.bit_count));
      end
    end
  end

  // Watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ir_pulse_distance_bit_decoder_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    irpd_pkg::pulse_t p;
    ir_code_t         res;
    int               one_v, hdr_v, gap_v;
    thresholds = '{irpd_pkg::GAP_LIMIT_RST, irpd_pkg::HEADER_LIMIT_RST,
                   irpd_pkg::ONE_LIMIT_RST, irpd_pkg::MIN_BITS_RST};
    bits_seen = '0;
    code_shift = '0;
    prev_low_len = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_regs();

    // Walk the directed table; typed rows carry their own expectation
    foreach (directed_rows[i]) begin
      p = '{directed_rows[i].ovf, directed_rows[i].low, directed_rows[i].len};
      drive_pulse(p);
      if (predict_pulse(p, res) && !directed_rows[i].typed) codes_due.push_back(res);
      if (directed_rows[i].typed && directed_rows[i].has_code)
        codes_due.push_back(ir_code_t'{directed_rows[i].code, directed_rows[i].bit_count});
    end

    // Gaps only by overflow, a bit is one if either length is nonzero, codes only when full
    run_phase(65535, 65535, 0, irpd_pkg::MAX_BITS, 1'b1, 300, 1'b0);
    // Every nonzero pulse is a gap, every gap with a bit emits
    run_phase(0, 0, 0, 0, 1'b1, 250, 1'b0);
    // Ordinary thresholds; receiver holds off while pulses keep coming
    one_v = $urandom_range(1500, 300);
    hdr_v = one_v + $urandom_range(2000, 200);
    gap_v = hdr_v + $urandom_range(8000, 500);
    run_phase(gap_v, hdr_v, one_v, $urandom_range(6, 0), 1'b0, 300, 1'b1);
    one_v = $urandom_range(65535, 0);
    hdr_v = $urandom_range(65535, 0);
    gap_v = $urandom_range(65535, 0);
    run_phase(gap_v, hdr_v, one_v, $urandom_range(48, 0), 1'b1, 300, 1'b0);
    run_phase(int'(irpd_pkg::GAP_LIMIT_RST), int'(irpd_pkg::HEADER_LIMIT_RST),
              int'(irpd_pkg::ONE_LIMIT_RST), int'(irpd_pkg::MIN_BITS_RST), 1'b1, 280, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ir_pulse_distance_bit_decoder_unit test passed");
    end else begin
      $display("ir_pulse_distance_bit_decoder_unit test failed");
    end
    $finish;
  end

endmodule
